### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SWM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("swm assertion failed");

// condition must never be true outside reset
`define SWM_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `SWM_ASSERT(lbl, clk, rstn, !(cond))

`endif

### hw/rtl/swm_pkg.sv
// package with constants and types of the sliding window median filter
package swm_pkg;

  localparam int unsigned MaxWindowDef  = 16;
  localparam int unsigned SampleBitsDef = 16;

  localparam int unsigned CfgW = 5;
  localparam logic [CfgW-1:0] WinSizeReset = 5'd5;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = 1;
  localparam logic [RegIdxW-1:0] RegWindowSize = 1'b0;

  typedef struct packed {
    logic clear;
    logic insert;
  } swm_sort_ctrl_t;

endpackage

### hw/rtl/swm_sample_if.sv
// stream interface carrying one sample item
interface swm_sample_if import swm_pkg::*; #(
  parameter int unsigned SampleBits = SampleBitsDef
) ();
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### hw/rtl/swm_median_if.sv
// stream interface carrying one median item
interface swm_median_if import swm_pkg::*; #(
  parameter int unsigned SampleBits = SampleBitsDef
) ();
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

### hw/rtl/swm_sorter.sv
// insertion sorter holding the window samples in ascending order
`include "assert_macros.svh"

module swm_sorter import swm_pkg::*; #(
  parameter int unsigned MaxWindow  = MaxWindowDef,
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  swm_sort_ctrl_t               ctrl_i,
  input  logic [SampleBits-1:0]        data_i,
  input  logic [$clog2(MaxWindow)-1:0] sel_i,
  output logic [SampleBits-1:0]        sel_o
);

  localparam int unsigned CntW = $clog2(MaxWindow + 1);

  logic [SampleBits-1:0] s_q [MaxWindow];
  logic [SampleBits-1:0] s_d [MaxWindow];
  logic [SampleBits-1:0] s_up [MaxWindow];
  logic [MaxWindow-1:0]  gt;
  logic [MaxWindow-1:0]  gt_prev;
  logic [CntW-1:0]       n_q;

  always_comb begin
    for (int i = 0; i < MaxWindow; i++) begin
      gt[i] = (CntW'(i) >= n_q) || ($signed(s_q[i]) > $signed(data_i));
    end
    gt_prev[0] = 1'b1;
    s_up[0]    = data_i;
    for (int i = 1; i < MaxWindow; i++) begin
      gt_prev[i] = gt[i-1];
      s_up[i]    = s_q[i-1];
    end
    for (int i = 0; i < MaxWindow; i++) begin
      if (!gt[i]) begin
        s_d[i] = s_q[i];
      end else if (!gt_prev[i] || i == 0) begin
        s_d[i] = data_i;
      end else begin
        s_d[i] = s_up[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert && !ctrl_i.clear) begin
      s_q <= s_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (ctrl_i.clear) begin
      n_q <= '0;
    end else if (ctrl_i.insert && n_q < CntW'(MaxWindow)) begin
      n_q <= n_q + CntW'(1);
    end
  end

  assign sel_o = s_q[sel_i];

  `SWM_ASSERT(a_no_overflow, clk_i, rst_ni, ctrl_i.insert && !ctrl_i.clear |-> n_q < CntW'(MaxWindow))
  `SWM_ASSERT(a_sorted_head, clk_i, rst_ni, n_q >= CntW'(2) |-> $signed(s_q[0]) <= $signed(s_q[1]))
  `SWM_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, n_q > CntW'(MaxWindow))

endmodule

### hw/rtl/sliding_window_median_top.sv
// sliding window median filter top level
//
// smp_i carries one signed q8.8 sample per item, med_o one signed q8.8 median.
// both are valid/ready channels; an item moves when valid and ready are high.
// the apb port holds window_size at address 0 (pready always high); the user
// must write it only while the block is idle, which the block does not enforce.
// every sample is written to the window memory. once the effective window
// (window_size held to 2..MaxWindow) of samples is held, the newest entries
// are read back one per cycle from the memory into an insertion sorter, then
// the middle entry (or the mean of the middle pair, truncated) becomes the median.
// an item that gives a result passes through the read, drain, select (and, for
// an even window, second select) and emit states, the reads going through the
// single memory read port; one that gives no result leaves the block idle.
// smp_i is ready only in the idle state, so the next item is taken in the same
// cycle as med_o goes valid at the earliest, never before the last is through.
// a stalled med_o keeps its median; the next sample is still taken and
// worked on, and its median waits until med_o has been taken.
// reset clears the fill count, the ring slot, window_size to 5 and the
// output; memory contents are not cleared and need no clearing pass.
`include "assert_macros.svh"

module sliding_window_median_top import swm_pkg::*; #(
  parameter int unsigned MaxWindow  = MaxWindowDef,
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  swm_sample_if.sink          smp_i,
  swm_median_if.source        med_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned IdxW = $clog2(MaxWindow);
  localparam int unsigned CntW = $clog2(MaxWindow + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_LO    = 3'd3;
  localparam logic [2:0] S_HI    = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [CfgW-1:0]       cfg_q;
  logic [2:0]            state_q, state_d;
  logic [IdxW-1:0]       slot_q, slot_d, slot_nx;
  logic [CntW-1:0]       fill_q, fill_d, fill_nx;
  logic [IdxW-1:0]       rp_q, rp_d;
  logic [CntW-1:0]       k_q, k_d;
  logic [SampleBits-1:0] win_mem [MaxWindow];
  logic [SampleBits-1:0] rd_q;
  logic                  rd_vld_q;
  logic                  re, we;
  logic [SampleBits-1:0] lo_q, lo_d;
  logic [SampleBits-1:0] res_q, res_d;
  logic [SampleBits-1:0] med_q;
  logic                  out_vld_q;
  logic                  emit;
  logic                  accept;
  logic                  cfg_we;
  logic [CntW-1:0]       eff;
  logic [IdxW-1:0]       mid;
  logic [IdxW-1:0]       sel;
  logic [SampleBits-1:0] sel_data;
  logic [SampleBits:0]   pair_sum;
  swm_sort_ctrl_t        sort_ctrl;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[ApbAddrW-1:2] == RegWindowSize);

  always_comb begin
    prdata = '0;
    if (paddr[ApbAddrW-1:2] == RegWindowSize) begin
      prdata = ApbDataW'(cfg_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= WinSizeReset;
    end else if (cfg_we) begin
      cfg_q <= pwdata[CfgW-1:0];
    end
  end

  // effective window
  always_comb begin
    if (cfg_q < CfgW'(2)) begin
      eff = CntW'(2);
    end else if (32'(cfg_q) > MaxWindow) begin
      eff = CntW'(MaxWindow);
    end else begin
      eff = CntW'(cfg_q);
    end
  end

  assign mid = IdxW'(eff >> 1);

  assign accept      = smp_i.valid && smp_i.ready;
  assign smp_i.ready = (state_q == S_IDLE);

  assign slot_nx = (slot_q == IdxW'(MaxWindow - 1)) ? '0 : slot_q + IdxW'(1);
  assign fill_nx = (fill_q == CntW'(MaxWindow)) ? fill_q : fill_q + CntW'(1);

  assign pair_sum = {lo_q[SampleBits-1], lo_q} + {sel_data[SampleBits-1], sel_data};

  always_comb begin
    state_d          = state_q;
    slot_d           = slot_q;
    fill_d           = fill_q;
    rp_d             = rp_q;
    k_d              = k_q;
    re               = 1'b0;
    we               = 1'b0;
    sort_ctrl.clear  = 1'b0;
    sort_ctrl.insert = rd_vld_q;
    sel              = mid;
    lo_d             = lo_q;
    res_d            = res_q;
    emit             = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          we     = 1'b1;
          slot_d = slot_nx;
          fill_d = fill_nx;
          rp_d   = slot_q;
          k_d    = '0;
          if (fill_nx >= eff) begin
            sort_ctrl.clear = 1'b1;
            state_d         = S_READ;
          end
        end
      end
      S_READ: begin
        re   = 1'b1;
        rp_d = (rp_q == '0) ? IdxW'(MaxWindow - 1) : rp_q - IdxW'(1);
        k_d  = k_q + CntW'(1);
        if (k_q == eff - CntW'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_LO;
      end
      S_LO: begin
        if (eff[0]) begin
          res_d   = sel_data;
          state_d = S_EMIT;
        end else begin
          sel     = mid - IdxW'(1);
          lo_d    = sel_data;
          state_d = S_HI;
        end
      end
      S_HI: begin
        res_d   = pair_sum[SampleBits:1];
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_vld_q || med_o.ready) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      slot_q    <= '0;
      fill_q    <= '0;
      rp_q      <= '0;
      k_q       <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      slot_q   <= slot_d;
      fill_q   <= fill_d;
      rp_q     <= rp_d;
      k_q      <= k_d;
      rd_vld_q <= re;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (med_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    res_q <= res_d;
    if (emit) begin
      med_q <= res_q;
    end
  end

  // window memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      win_mem[slot_q] <= smp_i.sample;
    end
    if (re) begin
      rd_q <= win_mem[rp_q];
    end
  end

  swm_sorter #(
    .MaxWindow  (MaxWindow),
    .SampleBits (SampleBits)
  ) u_sorter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sort_ctrl),
    .data_i (rd_q),
    .sel_i  (sel),
    .sel_o  (sel_data)
  );

  assign med_o.valid  = out_vld_q;
  assign med_o.median = med_q;

  `SWM_ASSERT_NEVER(a_fill_bound, clk_i, rst_ni, fill_q > CntW'(MaxWindow))
  `SWM_ASSERT(a_emit_rise, clk_i, rst_ni, $rose(out_vld_q) |-> $past(state_q) == S_EMIT)
  `SWM_ASSERT(a_read_drained, clk_i, rst_ni, state_q == S_LO |-> !rd_vld_q && $past(state_q) == S_DRAIN)

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// testbench of the median filter: directed table, then random items checked by a predictor
module tb_top;
  import swm_pkg::*;

  localparam int unsigned MaxWin = MaxWindowDef;
  localparam int unsigned SmpW = SampleBitsDef;
  localparam int unsigned ItemTarget = 700;
  localparam int unsigned CalmTail = 60;
  localparam int unsigned Settle = MaxWin + 12;
  localparam int unsigned WatchLimit = 4000;
  localparam logic [ApbAddrW-1:0] WinAddr = ApbAddrW'({RegWindowSize, 2'b00});

  typedef logic signed [SmpW-1:0] sample_t;
  typedef enum logic [0:0] {RowSample, RowWinSize} row_kind_e;
  typedef struct packed {
    row_kind_e       kind;
    logic [SmpW-1:0] value;
    logic            typed;
    logic            yields;
    logic [SmpW-1:0] median;
  } plan_row_t;

  localparam int unsigned PlanLen = 27;
  localparam plan_row_t Plan [PlanLen] = '{
    '{RowSample,  16'h8000, 1'b1, 1'b0, 16'h0000},
    '{RowSample,  16'h7FFF, 1'b1, 1'b0, 16'h0000},
    '{RowSample,  16'h0000, 1'b1, 1'b0, 16'h0000},
    '{RowSample,  16'hFFFF, 1'b1, 1'b0, 16'h0000},
    '{RowSample,  16'h0001, 1'b1, 1'b1, 16'h0000},
    '{RowSample,  16'h7FFF, 1'b0, 1'b0, 16'h0000},
    '{RowWinSize, 16'd2,    1'b0, 1'b0, 16'h0000},
    '{RowSample,  16'h7FFF, 1'b1, 1'b1, 16'h7FFF},
    '{RowSample,  16'h8000, 1'b1, 1'b1, 16'hFFFF},
    '{RowSample,  16'h8000, 1'b1, 1'b1, 16'h8000},
    '{RowWinSize, 16'd0,    1'b0, 1'b0, 16'h0000},
    '{RowSample,  16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{RowWinSize, 16'd31,   1'b0, 1'b0, 16'h0000},
    '{RowSample,  16'h00FF, 1'b0, 1'b0, 16'h0000},
    '{RowSample,  16'h0100, 1'b0, 1'b0, 16'h0000},
    '{RowSample,  16'hFF00, 1'b0, 1'b0, 16'h0000},
    '{RowSample,  16'h5555, 1'b0, 1'b0, 16'h0000},
    '{RowSample,  16'hAAAA, 1'b0, 1'b0, 16'h0000},
    '{RowSample,  16'h0080, 1'b0, 1'b0, 16'h0000},
    '{RowWinSize, 16'd17,   1'b0, 1'b0, 16'h0000},
    '{RowSample,  16'h7FFF, 1'b0, 1'b0, 16'h0000},
    '{RowWinSize, 16'd1,    1'b0, 1'b0, 16'h0000},
    '{RowSample,  16'h0000, 1'b0, 1'b0, 16'h0000},
    '{RowWinSize, 16'd16,   1'b0, 1'b0, 16'h0000},
    '{RowSample,  16'h8001, 1'b0, 1'b0, 16'h0000},
    '{RowWinSize, 16'd3,    1'b0, 1'b0, 16'h0000},
    '{RowSample,  16'h0002, 1'b0, 1'b0, 16'h0000}
  };
  localparam logic [SmpW-1:0] Extremes [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  swm_sample_if #(.SampleBits(SmpW)) smp_if ();
  swm_median_if #(.SampleBits(SmpW)) med_if ();

  sliding_window_median_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .smp_i   (smp_if),
    .med_o   (med_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of the filter state
  sample_t         ring [MaxWin];
  int unsigned     ring_slot;
  int unsigned     ring_fill;
  logic [CfgW-1:0] win_cfg;

  logic [SmpW-1:0] pending_medians [$];
  int unsigned     fail_cnt;
  int unsigned     idle_cycles;
  int unsigned     stall_left;
  bit              stall_on;
  bit              calm;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic bit slide_and_median(input sample_t s, output logic [SmpW-1:0] med);
    sample_t             pick [MaxWin];
    sample_t             key;
    logic signed [SmpW:0] pair_sum;
    int unsigned         w;
    int                  j;
    ring[ring_slot] = s;
    ring_slot = (ring_slot + 1) % MaxWin;
    if (ring_fill < MaxWin) ring_fill++;
    w = (win_cfg < 2) ? 2 : ((win_cfg > MaxWin) ? MaxWin : win_cfg);
    med = '0;
    if (ring_fill < w) return 1'b0;
    for (int k = 0; k < w; k++) pick[k] = ring[(ring_slot + MaxWin - 1 - k) % MaxWin];
    for (int i = 1; i < w; i++) begin
      key = pick[i];
      j = i;
      while (j > 0 && pick[j-1] > key) begin
        pick[j] = pick[j-1];
        j--;
      end
      pick[j] = key;
    end
    if (w % 2 == 1) begin
      med = pick[w/2];
    end else begin
      pair_sum = pick[w/2-1] + pick[w/2];
      med = pair_sum[SmpW:1];
    end
    return 1'b1;
  endfunction

  function automatic void queue_median(input logic [SmpW-1:0] m);
    pending_medians = {pending_medians, m};
  endfunction

  task automatic apb_rw(input bit wr, input logic [ApbDataW-1:0] wdata,
                        output logic [ApbDataW-1:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= WinAddr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_window(input logic [CfgW-1:0] win, input logic [ApbDataW-1:0] upper);
    logic [ApbDataW-1:0] rd;
    smp_if.valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    apb_rw(1'b1, (upper & ~ApbDataW'({CfgW{1'b1}})) | ApbDataW'(win), rd);
    win_cfg = win;
    apb_rw(1'b0, '0, rd);
    if (rd !== ApbDataW'(win)) begin
      $error("window_size readback mismatch: expected %0d, actual %0d", win, rd);
      fail_cnt++;
    end
  endtask

  task automatic send_sample(input logic [SmpW-1:0] s, input bit typed, input bit yields,
                             input logic [SmpW-1:0] typed_med);
    logic [SmpW-1:0] med;
    bit              got;
    if (stall_on && !calm && $urandom_range(0, 5) == 0) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    smp_if.valid <= 1'b1;
    smp_if.sample <= s;
    do @(posedge clk_i); while (!smp_if.ready);
    got = slide_and_median(sample_t'(s), med);
    if (typed) begin
      if (yields) queue_median(typed_med);
    end else if (got) begin
      queue_median(med);
    end
  endtask

  always @(posedge clk_i) begin
    if (!stall_on || calm) begin
      med_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      med_if.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 13);
      med_if.ready <= 1'b0;
    end else begin
      med_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    logic [SmpW-1:0] want;
    if (rst_ni && med_if.valid && med_if.ready) begin
      if (pending_medians.size() == 0) begin
        $error("median item with none expected: actual %0d", $signed(med_if.median));
        fail_cnt++;
      end else begin
        want = pending_medians.pop_front();
        if (med_if.median !== want) begin
          $error("median mismatch: expected %0d, actual %0d", $signed(want),
                 $signed(med_if.median));
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (smp_if.valid && smp_if.ready) || (med_if.valid && med_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [ApbDataW-1:0] rd;
    logic [CfgW-1:0]     win;
    logic [SmpW-1:0]     s;
    logic [SmpW-1:0]     cluster;
    int unsigned         sent;
    int unsigned         run_len;
    rst_ni = 1'b0;
    smp_if.valid = 1'b0;
    smp_if.sample = '0;
    med_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_cnt = 0;
    idle_cycles = 0;
    stall_left = 0;
    stall_on = 1'b1;
    calm = 1'b0;
    ring_slot = 0;
    ring_fill = 0;
    win_cfg = WinSizeReset;
    sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    apb_rw(1'b0, '0, rd);
    if (rd !== ApbDataW'(WinSizeReset)) begin
      $error("window_size reset mismatch: expected %0d, actual %0d", WinSizeReset, rd);
      fail_cnt++;
    end

    for (int i = 0; i < PlanLen; i++) begin
      if (Plan[i].kind == RowWinSize) set_window(Plan[i].value[CfgW-1:0], '0);
      else send_sample(Plan[i].value, Plan[i].typed, Plan[i].yields, Plan[i].median);
    end

    while (sent < ItemTarget) begin
      case ($urandom_range(0, 9))
        0: win = CfgW'($urandom_range(0, 1));
        1: win = CfgW'($urandom_range(MaxWin + 1, (1 << CfgW) - 1));
        2: win = $urandom_range(0, 1) ? CfgW'(2) : CfgW'(MaxWin);
        default: win = CfgW'($urandom_range(2, MaxWin));
      endcase
      set_window(win, $urandom_range(0, 1) ? ApbDataW'($urandom) : '0);
      stall_on = $urandom_range(0, 3) != 0;
      cluster = SmpW'($urandom);
      run_len = $urandom_range(4, 48);
      for (int n = 0; n < run_len && sent < ItemTarget; n++) begin
        if (ItemTarget - sent <= CalmTail) calm = 1'b1;
        case ($urandom_range(0, 7))
          0: s = Extremes[$urandom_range(0, 3)];
          1, 2: s = cluster + SmpW'($urandom_range(0, 6)) - SmpW'(3);
          default: s = SmpW'($urandom);
        endcase
        send_sample(s, 1'b0, 1'b0, '0);
        sent++;
      end
    end

    calm = 1'b1;
    smp_if.valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
